### hdl/tpsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsu_pkg
// Shared types for the task priority selector: command codes, controller
// states and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tpsu_pkg;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_EDIT   = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_EXEC   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_EDIT_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic ctr_clear;
		logic scan_rd;
		logic best_init;
		logic add_wr;
		logic edit_rd;
		logic edit_wr;
		logic rm_wr;
		logic kill_wr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic  ctr_last;
		logic  id_ok;
		kind_t kind;
	} sts_t;

endpackage

### hdl/tpsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsu_ctrl
// Controller: sequences the clearing pass, the single-word commands and the
// linear scan for execute-top.
// ----------------------------------------------------------------------------
module tpsu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tpsu_pkg::sts_t  sts,
	output tpsu_pkg::cmd_t  cmd,
	output logic            busy
);

	tpsu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpsu_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			tpsu_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.ctr_last) begin
					state_d = tpsu_pkg::ST_IDLE;
				end
			end
			tpsu_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = tpsu_pkg::ST_DECODE;
				end
			end
			tpsu_pkg::ST_DECODE: begin
				state_d = tpsu_pkg::ST_IDLE;
				if (sts.kind == tpsu_pkg::KIND_EXEC) begin
					cmd.ctr_clear = 1'b1;
					cmd.best_init = 1'b1;
					state_d       = tpsu_pkg::ST_SCAN;
				end else if (sts.id_ok) begin
					unique case (sts.kind)
						tpsu_pkg::KIND_ADD:    cmd.add_wr = 1'b1;
						tpsu_pkg::KIND_EDIT: begin
							cmd.edit_rd = 1'b1;
							state_d     = tpsu_pkg::ST_EDIT_WR;
						end
						tpsu_pkg::KIND_REMOVE: cmd.rm_wr = 1'b1;
						default:               cmd = '0;
					endcase
				end
			end
			tpsu_pkg::ST_EDIT_WR: begin
				cmd.edit_wr = 1'b1;
				state_d     = tpsu_pkg::ST_IDLE;
			end
			tpsu_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.ctr_last) begin
					state_d = tpsu_pkg::ST_SCAN_END;
				end
			end
			tpsu_pkg::ST_SCAN_END: begin
				state_d = tpsu_pkg::ST_FINISH;
			end
			tpsu_pkg::ST_FINISH: begin
				cmd.kill_wr = 1'b1;
				cmd.emit    = 1'b1;
				state_d     = tpsu_pkg::ST_IDLE;
			end
			default: begin
				state_d = tpsu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/tpsu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsu_dp
// Datapath: live, priority and owner memories, request registers, the slot
// counter, the running best of the scan and the result register.
// ----------------------------------------------------------------------------
module tpsu_dp #(
	parameter int TASK_SLOTS    = 1024,
	parameter int PRIORITY_BITS = 16,
	parameter int USER_BITS     = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      kind,
	input  logic [9:0]      task_id,
	input  logic [15:0]     user_id,
	input  logic [15:0]     priority_req,
	input  tpsu_pkg::cmd_t  cmd,
	output tpsu_pkg::sts_t  sts,
	output logic            done,
	output logic            found,
	output logic [15:0]     owner_user
);

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	logic                     live_mem  [TASK_SLOTS];
	logic [PRIORITY_BITS-1:0] prio_mem  [TASK_SLOTS];
	logic [USER_BITS-1:0]     owner_mem [TASK_SLOTS];

	tpsu_pkg::kind_t          kind_q;
	logic [9:0]               id_q;
	logic [USER_BITS-1:0]     user_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [IDX_W-1:0]         ctr_q;

	logic                     valid_s1;
	logic                     live_s1;
	logic [PRIORITY_BITS-1:0] prio_s1;
	logic [USER_BITS-1:0]     owner_s1;
	logic [IDX_W-1:0]         slot_s1;

	logic                     any_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic [USER_BITS-1:0]     best_owner_q;
	logic [IDX_W-1:0]         best_slot_q;

	logic                     done_q;
	logic                     found_q;
	logic [15:0]              owner_q;

	logic [31:0]              id_wide;
	logic [31:0]              user_wide;
	logic [31:0]              prio_wide;
	logic [31:0]              best_owner_wide;
	logic [IDX_W-1:0]         id_idx;
	logic [IDX_W-1:0]         rd_addr;
	logic                     take;

	assign id_wide         = 32'(id_q);
	assign id_idx          = id_wide[IDX_W-1:0];
	assign user_wide       = 32'(user_id);
	assign prio_wide       = 32'(priority_req);
	assign best_owner_wide = 32'(best_owner_q);
	assign rd_addr         = cmd.edit_rd ? id_idx : ctr_q;

	assign sts.ctr_last = (ctr_q == IDX_W'(TASK_SLOTS - 1));
	assign sts.id_ok    = (id_wide < 32'(TASK_SLOTS));
	assign sts.kind     = kind_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= tpsu_pkg::kind_t'(kind);
			id_q   <= task_id;
			user_q <= user_wide[USER_BITS-1:0];
			prio_q <= prio_wide[PRIORITY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.ctr_clear) begin
			ctr_q <= '0;
		end else if (cmd.clr_wr || cmd.scan_rd) begin
			ctr_q <= sts.ctr_last ? '0 : ctr_q + 1'b1;
		end
	end

	// live memory: one write port shared by clear, add, edit-less remove, kill
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			live_mem[ctr_q] <= 1'b0;
		end else if (cmd.add_wr) begin
			live_mem[id_idx] <= 1'b1;
		end else if (cmd.rm_wr) begin
			live_mem[id_idx] <= 1'b0;
		end else if (cmd.kill_wr && any_q) begin
			live_mem[best_slot_q] <= 1'b0;
		end
		live_s1 <= live_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr || (cmd.edit_wr && live_s1)) begin
			prio_mem[id_idx] <= prio_q;
		end
		prio_s1 <= prio_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			owner_mem[id_idx] <= user_q;
		end
		owner_s1 <= owner_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= ctr_q;
	end

	// ascending scan with >= keeps the highest slot among equal priorities
	assign take = valid_s1 && live_s1 && (!any_q || (prio_s1 >= best_prio_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (cmd.best_init) begin
			any_q <= 1'b0;
		end else if (take) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_prio_q  <= prio_s1;
			best_owner_q <= owner_s1;
			best_slot_q  <= slot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			owner_q <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.emit) begin
				found_q <= any_q;
				owner_q <= any_q ? best_owner_wide[15:0] : 16'd0;
			end
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign owner_user = owner_q;

	a_empty_owner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> owner_user == 16'd0)
		else $error("empty result carries a nonzero owner");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.add_wr, cmd.rm_wr, cmd.kill_wr, cmd.edit_wr}))
		else $error("two table writes in one cycle");

	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |=> valid_s1)
		else $error("scan read lost its data stage");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit)
		else $error("result emitted twice");

endmodule

### hdl/task_priority_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_priority_selector_unit
// Indexed task table with execute-highest-priority selection.
// ----------------------------------------------------------------------------
// Usage: drive kind, task_id, user_id and priority_req and raise start; the
// word is taken at a clock edge where start is high and busy is low.
// Add and remove hold busy through the decode state after acceptance, and
// edit through the decode and edit write states. Add, edit and remove give
// no result.
// Execute-top walks every slot of the table through the memory read port,
// one slot per cycle, holding busy through the decode, scan, scan-end and
// finish states; its result shows on found/owner_user with done high for
// exactly one cycle, the first cycle in which busy is low. The receiver
// cannot stall; the next word may be started in the same cycle that done
// is high.
// After reset the block clears every live mark, one slot per cycle, and
// holds busy high through that pass before accepting the first word.
// Task ids not below TASK_SLOTS are ignored by add, edit and remove.
// ----------------------------------------------------------------------------
module task_priority_selector_unit #(
	parameter int TASK_SLOTS    = 1024,
	parameter int PRIORITY_BITS = 16,
	parameter int USER_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [9:0]  task_id,
	input  logic [15:0] user_id,
	input  logic [15:0] priority_req,
	output logic        done,
	output logic        found,
	output logic [15:0] owner_user
);

	tpsu_pkg::cmd_t cmd;
	tpsu_pkg::sts_t sts;

	tpsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tpsu_dp #(
		.TASK_SLOTS    (TASK_SLOTS),
		.PRIORITY_BITS (PRIORITY_BITS),
		.USER_BITS     (USER_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (kind),
		.task_id      (task_id),
		.user_id      (user_id),
		.priority_req (priority_req),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.found        (found),
		.owner_user   (owner_user)
	);

endmodule

### bench/task_priority_selector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_priority_selector_checker
// Watches the command and result channels of the task priority selector,
// keeps a shadow task table, predicts each execute-top result and compares
// it field by field against what the block reports on done.
// ----------------------------------------------------------------------------
module task_priority_selector_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [9:0]  task_id,
	input  logic [15:0] user_id,
	input  logic [15:0] priority_req,
	input  logic        done,
	input  logic        found,
	input  logic [15:0] owner_user,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        found;
		logic [15:0] owner;
	} exec_word_t;

	logic        live_tab [1024];
	logic [15:0] prio_tab [1024];
	logic [15:0] owner_tab [1024];
	exec_word_t  exec_q[$];

	assign pending = exec_q.size();

	function automatic exec_word_t pick_top();
		exec_word_t w;
		int best;
		best = -1;
		for (int s = 0; s < 1024; s++) begin
			if (live_tab[s] && (best < 0 || prio_tab[s] >= prio_tab[best]))
				best = s;
		end
		if (best < 0) begin
			w = '0;
		end else begin
			live_tab[best] = 1'b0;
			w.found = 1'b1;
			w.owner = owner_tab[best];
		end
		return w;
	endfunction

	task automatic apply_word(input tpsu_pkg::kind_t k, input logic [9:0] id,
			input logic [15:0] usr, input logic [15:0] pr);
		unique case (k)
			tpsu_pkg::KIND_EXEC: begin
				exec_q.push_back(pick_top());
			end
			tpsu_pkg::KIND_ADD: begin
				prio_tab[id] = pr;
				owner_tab[id] = usr;
				live_tab[id] = 1'b1;
			end
			tpsu_pkg::KIND_EDIT: begin
				if (live_tab[id])
					prio_tab[id] = pr;
			end
			default: begin
				live_tab[id] = 1'b0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		exec_word_t want;
		if (!arst_n) begin
			fail_count <= 0;
			exec_q.delete();
			for (int s = 0; s < 1024; s++) begin
				live_tab[s] = 1'b0;
				prio_tab[s] = '0;
				owner_tab[s] = '0;
			end
		end else begin
			// check the result first: a new word may be taken in the done cycle
			if (done) begin
				if (exec_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result found=%0b owner=%0h",
							$time, found, owner_user);
					fail_count <= fail_count + 1;
				end else begin
					want = exec_q.pop_front();
					if (found !== want.found || owner_user !== want.owner) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp found=%0b owner=%0h got found=%0b owner=%0h",
								$time, want.found, want.owner, found, owner_user);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				apply_word(tpsu_pkg::kind_t'(kind), task_id, user_id, priority_req);
		end
	end

endmodule

### bench/task_priority_selector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_priority_selector_unit_tb
// Drives directed and random command words into the task priority selector
// in bursts with random gaps; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module task_priority_selector_unit_tb;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [9:0]  task_id;
	logic [15:0] user_id;
	logic [15:0] priority_req;
	logic        done;
	logic        found;
	logic [15:0] owner_user;
	int          fail_count;
	int          pending;
	int          cycle_count;

	localparam int CYCLE_LIMIT = 8000000;

	task_priority_selector_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.task_id(task_id), .user_id(user_id), .priority_req(priority_req),
		.done(done), .found(found), .owner_user(owner_user)
	);

	task_priority_selector_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.task_id(task_id), .user_id(user_id), .priority_req(priority_req),
		.done(done), .found(found), .owner_user(owner_user),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// hold start until the word is taken, then drop it unless told to go on
	task automatic send_word(input tpsu_pkg::kind_t k, input logic [9:0] id,
			input logic [15:0] usr, input logic [15:0] pr, input bit keep);
		start <= 1'b1;
		kind <= k;
		task_id <= id;
		user_id <= usr;
		priority_req <= pr;
		do @(posedge clk); while (busy);
		if (!keep)
			start <= 1'b0;
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	// step one edge so the checker has logged the last word, then drain
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// ids drawn from a narrow pool most of the time so edits and removes hit
	function automatic logic [9:0] rand_id();
		if ($urandom_range(0, 3) != 0)
			return 10'($urandom_range(0, 31));
		return 10'($urandom);
	endfunction

	function automatic logic [15:0] rand_prio();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3));
			1: return 16'hFFFF - 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_word(input bit keep);
		int r;
		tpsu_pkg::kind_t k;
		r = $urandom_range(0, 99);
		if (r < 40) k = tpsu_pkg::KIND_ADD;
		else if (r < 60) k = tpsu_pkg::KIND_EDIT;
		else if (r < 75) k = tpsu_pkg::KIND_REMOVE;
		else k = tpsu_pkg::KIND_EXEC;
		send_word(k, rand_id(), 16'($urandom), rand_prio(), keep);
	endtask

	initial begin
		int sent;
		int burst;
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = tpsu_pkg::KIND_ADD;
		task_id = '0;
		user_id = '0;
		priority_req = '0;
		idle_cycles(10);
		arst_n <= 1'b1;

		// directed: empty table, extremes, ties, dead edit/remove, overwrite
		send_word(tpsu_pkg::KIND_EXEC, 10'd0, 16'hFFFF, 16'hFFFF, 0);
		send_word(tpsu_pkg::KIND_ADD, 10'd0, 16'h0000, 16'h0000, 1);
		send_word(tpsu_pkg::KIND_ADD, 10'd1023, 16'hFFFF, 16'hFFFF, 1);
		send_word(tpsu_pkg::KIND_ADD, 10'd512, 16'hA5A5, 16'hFFFF, 1);
		send_word(tpsu_pkg::KIND_ADD, 10'd3, 16'h5A5A, 16'h0000, 1);
		send_word(tpsu_pkg::KIND_EDIT, 10'd7, 16'h1234, 16'hFFFF, 1);
		send_word(tpsu_pkg::KIND_REMOVE, 10'd9, 16'h0, 16'h0, 1);
		send_word(tpsu_pkg::KIND_EXEC, 10'd0, 16'h0, 16'h0, 1);
		send_word(tpsu_pkg::KIND_EXEC, 10'd0, 16'h0, 16'h0, 1);
		send_word(tpsu_pkg::KIND_ADD, 10'd3, 16'h7777, 16'h0001, 1);
		send_word(tpsu_pkg::KIND_EDIT, 10'd0, 16'h0, 16'h8000, 1);
		send_word(tpsu_pkg::KIND_EXEC, 10'd0, 16'h0, 16'h0, 1);
		send_word(tpsu_pkg::KIND_REMOVE, 10'd3, 16'h0, 16'h0, 1);
		send_word(tpsu_pkg::KIND_EXEC, 10'd0, 16'h0, 16'h0, 1);
		send_word(tpsu_pkg::KIND_EXEC, 10'd1023, 16'h0, 16'h0, 0);

		// let every expected result arrive before going on
		wait_drained();

		sent = 0;
		while (sent < 2000) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst; i++) begin
				random_word(i != burst - 1);
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 40));
			if (sent > 1000 && sent < 1030)
				wait_drained();
		end

		wait_drained();
		idle_cycles(20);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
